FILE: rtl/smss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smss_pkg
// Shared constants and control types of the spatial midpoint split sort core.
// ----------------------------------------------------------------------------
package smss_pkg;

	// default sizing
	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 32;

	// item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DROP  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// bounding box unit control
	typedef struct packed {
		logic clr;   // restart min/max tracking
		logic acc;   // fold in one point
		logic calc;  // latch extents
	} bbox_ctl_t;

	// bounding box unit result
	typedef struct packed {
		logic [1:0] axis;  // axis of greatest extent, lowest on ties
		logic       flat;  // greatest extent is zero
	} bbox_res_t;

endpackage

FILE: rtl/smss_bbox.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smss_bbox
// Tracks per-axis min and max over a streamed range of points, then picks the
// widest axis and its midpoint split value.
// ----------------------------------------------------------------------------
module smss_bbox #(
	parameter int CW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  smss_pkg::bbox_ctl_t   ctl,
	input  logic [3*CW-1:0]       pt,
	output smss_pkg::bbox_res_t   res,
	output logic [CW-1:0]         split
);

	logic signed [CW-1:0] mn_q [3];
	logic signed [CW-1:0] mx_q [3];
	logic        [CW-1:0] ext_q [3];
	logic                 first_q;
	logic signed [CW-1:0] v [3];
	logic        [1:0]    ax;
	logic        [CW-1:0] best;

	// slice the point into axes
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			v[a] = pt[a*CW +: CW];
		end
	end

	// mark the first point of a range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (ctl.clr) begin
			first_q <= 1'b1;
		end else if (ctl.acc) begin
			first_q <= 1'b0;
		end
	end

	// fold points into the box, latch extents
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (ctl.acc) begin
				if (first_q || v[a] < mn_q[a]) mn_q[a] <= v[a];
				if (first_q || v[a] > mx_q[a]) mx_q[a] <= v[a];
			end
			if (ctl.calc) begin
				ext_q[a] <= mx_q[a] - mn_q[a];
			end
		end
	end

	// pick the widest axis, lowest on ties
	always_comb begin
		ax   = 2'd0;
		best = ext_q[0];
		if (ext_q[1] > best) begin
			ax   = 2'd1;
			best = ext_q[1];
		end
		if (ext_q[2] > best) begin
			ax   = 2'd2;
			best = ext_q[2];
		end
		res.axis = ax;
		res.flat = (best == '0);
		split    = mn_q[ax] + (best >> 1);
	end

endmodule

FILE: rtl/spatial_midpoint_split_sort_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_midpoint_split_sort_core
// Collects 3D points and reorders them in place by recursive midpoint splits.
// ----------------------------------------------------------------------------
// A load without last_point leaves busy low. A read passes through the read
// state and gives its result (strobe done) from the result registers. A closing
// load sorts the set held in the point memory and gives done with the point
// count when the sort ends. Each range is popped from the stack and scanned for
// its min/max; unless its box is flat, it is then partitioned about the midpoint
// of its widest axis by pointer steps and swaps, and its halves of two or more
// points are pushed, all bound by the two read ports of the point memory.
// Results cannot be held off: done is high for one cycle and the receiver must
// take it then.
// ----------------------------------------------------------------------------
module spatial_midpoint_split_sort_core #(
	parameter int MAX_POINTS = smss_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = smss_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic               last_point,
	input  logic        [9:0]  read_index,
	output logic               done,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic        [10:0] point_count,
	output logic        [1:0]  status
);

	localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int IW   = (CNTW > 10) ? CNTW : 10;
	localparam int PW   = 3 * CW;
	localparam logic [CNTW-1:0] MAX_C = CNTW'(MAX_POINTS);
	localparam logic [CNTW-1:0] TWO_C = CNTW'(2);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_READ  = 12'b000000000010,
		S_POP   = 12'b000000000100,
		S_STK   = 12'b000000001000,
		S_SCAN  = 12'b000000010000,
		S_AXIS  = 12'b000000100000,
		S_PICK  = 12'b000001000000,
		S_PRD   = 12'b000010000000,
		S_PEV   = 12'b000100000000,
		S_SWB   = 12'b001000000000,
		S_PUSHR = 12'b010000000000,
		S_PUSHL = 12'b100000000000
	} state_t;

	// memories
	logic [PW-1:0]     pt_mem  [MAX_POINTS];
	logic [2*CNTW-1:0] stk_mem [MAX_POINTS];

	state_t            state_q;
	logic [CNTW-1:0]   held_q;
	logic              closed_q;
	logic              drop_q;
	logic [CNTW-1:0]   top_q;
	logic              sort_q;
	logic              inrange_q;
	logic [PW-1:0]     rda_q, rdb_q, swap_q;
	logic [2*CNTW-1:0] stk_q;
	logic [CNTW-1:0]   lo_q, n_q, l_q, rp_q, scan_q, left_q;
	logic              scan_v_s1;
	logic [1:0]        axis_q;
	logic signed [CW-1:0] split_q;
	logic              done_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [10:0]       cnt_q;
	logic [1:0]        st_q;

	logic              acc;
	logic [CNTW-1:0]   base, new_cnt, n_r, n_l;
	logic              fits;
	logic              pm_we, stk_we;
	logic [AW-1:0]     pm_wa, pm_ra, pm_rb, stk_wa, stk_ra;
	logic [PW-1:0]     pm_wd;
	logic [2*CNTW-1:0] stk_wd;
	logic signed [CW-1:0] pl, pr, ox, oy, oz;
	logic              gt_l, gt_r;
	smss_pkg::bbox_ctl_t bctl;
	smss_pkg::bbox_res_t bres;
	logic [CW-1:0]     bsplit;

	assign busy = (state_q != S_IDLE);
	assign acc  = start && !busy;

	// load bookkeeping
	assign base    = closed_q ? '0 : held_q;
	assign fits    = (base < MAX_C);
	assign new_cnt = fits ? base + CNTW'(1) : base;

	// child range sizes
	assign n_r = lo_q + n_q - l_q;
	assign n_l = l_q - lo_q;

	// partition compare on the chosen axis
	assign pl   = rda_q[axis_q*CW +: CW];
	assign pr   = rdb_q[axis_q*CW +: CW];
	assign gt_l = (pl > split_q);
	assign gt_r = (pr > split_q);

	// memory ports
	always_comb begin
		pm_we  = 1'b0;
		pm_wa  = base[AW-1:0];
		pm_wd  = {coord_z[CW-1:0], coord_y[CW-1:0], coord_x[CW-1:0]};
		pm_ra  = AW'(read_index);
		pm_rb  = AW'(rp_q - CNTW'(1));
		stk_we = 1'b0;
		stk_wa = top_q[AW-1:0];
		stk_wd = {l_q, n_r};
		stk_ra = AW'(top_q - CNTW'(1));
		case (state_q)
			S_IDLE: begin
				pm_we  = acc && (kind == smss_pkg::KIND_LOAD) && fits;
				stk_wa = '0;
				stk_wd = {CNTW'(0), new_cnt};
				stk_we = acc && (kind == smss_pkg::KIND_LOAD) && last_point
					&& (new_cnt >= TWO_C);
			end
			S_SCAN: pm_ra = scan_q[AW-1:0];
			S_PRD:  pm_ra = l_q[AW-1:0];
			S_PEV: begin
				pm_we = gt_l && !gt_r;
				pm_wa = l_q[AW-1:0];
				pm_wd = rdb_q;
			end
			S_SWB: begin
				pm_we = 1'b1;
				pm_wa = AW'(rp_q - CNTW'(1));
				pm_wd = swap_q;
			end
			S_PUSHR: stk_we = (n_r >= TWO_C) && (top_q < MAX_C);
			S_PUSHL: begin
				stk_wd = {lo_q, n_l};
				stk_we = (n_l >= TWO_C) && (top_q < MAX_C);
			end
			default: ;
		endcase
	end

	// point memory, two read ports
	always_ff @(posedge clk) begin
		if (pm_we) pt_mem[pm_wa] <= pm_wd;
		rda_q <= pt_mem[pm_ra];
		rdb_q <= pt_mem[pm_rb];
	end

	// range stack memory
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		stk_q <= stk_mem[stk_ra];
	end

	// bounding box control
	always_comb begin
		bctl.clr  = (state_q == S_STK);
		bctl.acc  = scan_v_s1;
		bctl.calc = (state_q == S_AXIS);
	end

	smss_bbox #(
		.CW (CW)
	) u_bbox (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (bctl),
		.pt     (rda_q),
		.res    (bres),
		.split  (bsplit)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			held_q    <= '0;
			closed_q  <= 1'b1;
			drop_q    <= 1'b0;
			top_q     <= '0;
			sort_q    <= 1'b0;
			scan_v_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			scan_v_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc && kind == smss_pkg::KIND_READ) begin
						state_q <= S_READ;
					end else if (acc) begin
						held_q   <= new_cnt;
						drop_q   <= (closed_q ? 1'b0 : drop_q) | !fits;
						closed_q <= last_point;
						if (last_point) begin
							top_q   <= (new_cnt >= TWO_C) ? CNTW'(1) : '0;
							sort_q  <= 1'b1;
							state_q <= S_POP;
						end
					end
				end
				S_READ: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_POP: begin
					if (top_q == '0) begin
						done_q  <= 1'b1;
						sort_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						top_q   <= top_q - CNTW'(1);
						state_q <= S_STK;
					end
				end
				S_STK: state_q <= S_SCAN;
				S_SCAN: begin
					if (left_q != '0) begin
						scan_v_s1 <= 1'b1;
					end else if (!scan_v_s1) begin
						state_q <= S_AXIS;
					end
				end
				S_AXIS: state_q <= S_PICK;
				S_PICK: state_q <= bres.flat ? S_POP : S_PRD;
				S_PRD:  state_q <= (l_q < rp_q) ? S_PEV : S_PUSHR;
				S_PEV:  state_q <= (gt_l && !gt_r) ? S_SWB : S_PRD;
				S_SWB:  state_q <= S_PRD;
				S_PUSHR: begin
					if (stk_we) top_q <= top_q + CNTW'(1);
					state_q <= S_PUSHL;
				end
				S_PUSHL: begin
					if (stk_we) top_q <= top_q + CNTW'(1);
					state_q <= S_POP;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// range and pointer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: inrange_q <= (IW'(read_index) < IW'(held_q));
			S_STK: begin
				lo_q   <= stk_q[2*CNTW-1:CNTW];
				n_q    <= stk_q[CNTW-1:0];
				scan_q <= stk_q[2*CNTW-1:CNTW];
				left_q <= stk_q[CNTW-1:0];
			end
			S_SCAN: begin
				if (left_q != '0) begin
					scan_q <= scan_q + CNTW'(1);
					left_q <= left_q - CNTW'(1);
				end
			end
			S_PICK: begin
				axis_q  <= bres.axis;
				split_q <= bsplit;
				l_q     <= lo_q;
				rp_q    <= lo_q + n_q;
			end
			S_PEV: begin
				if (gt_l && !gt_r) begin
					swap_q <= rda_q;
				end else begin
					if (!gt_l) l_q <= l_q + CNTW'(1);
					if (gt_r) rp_q <= rp_q - CNTW'(1);
				end
			end
			S_SWB: begin
				l_q  <= l_q + CNTW'(1);
				rp_q <= rp_q - CNTW'(1);
			end
			default: ;
		endcase
	end

	// slice the read point
	assign ox = rda_q[0 +: CW];
	assign oy = rda_q[CW +: CW];
	assign oz = rda_q[2*CW +: CW];

	// result registers
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			px_q  <= inrange_q ? 32'(ox) : '0;
			py_q  <= inrange_q ? 32'(oy) : '0;
			pz_q  <= inrange_q ? 32'(oz) : '0;
			cnt_q <= 11'(held_q);
			st_q  <= inrange_q ? smss_pkg::ST_OK : smss_pkg::ST_RANGE;
		end else if (state_q == S_POP && top_q == '0 && sort_q) begin
			px_q  <= '0;
			py_q  <= '0;
			pz_q  <= '0;
			cnt_q <= 11'(held_q);
			st_q  <= drop_q ? smss_pkg::ST_DROP : smss_pkg::ST_OK;
		end
	end

	assign done        = done_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign point_z     = pz_q;
	assign point_count = cnt_q;
	assign status      = st_q;

endmodule

FILE: rtl/smss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smss_checker
// Port-level checks of the sort core, attached by bind.
// ----------------------------------------------------------------------------
module smss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               kind,
	input logic               done,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic signed [31:0] point_z,
	input logic [1:0]         status
);

	// a read transfer gives its result once the core has passed its read state
	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == smss_pkg::KIND_READ |-> ##2 done)
		else $error("read result missing");

	// a result is never followed by another at once
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back results");

	// result appears with the core free
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	// out-of-range read carries zero coordinates
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == smss_pkg::ST_RANGE |->
			point_x == 0 && point_y == 0 && point_z == 0)
		else $error("nonzero point on range error");

endmodule

bind spatial_midpoint_split_sort_core smss_checker u_smss_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.kind    (kind),
	.done    (done),
	.point_x (point_x),
	.point_y (point_y),
	.point_z (point_z),
	.status  (status)
);
